/* design/hjg_pkg.sv */
// ----------------------------------------------------------------------------
// hjg_pkg
// Shared widths, defaults, controller states and the command and status
// bundles that connect the Halton jitter controller and datapath.
// ----------------------------------------------------------------------------
package hjg_pkg;

    localparam int FRAME_W         = 32;
    localparam int JIT_W           = 16;
    localparam int CFG_W           = 9;
    localparam int CFG_RESET       = 8;
    localparam int MAX_SAMPLES_DEF = 256;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic [31:0] JIT_POS_MAX = 32'd32767;
    localparam logic [31:0] JIT_NEG_MAG = 32'd32768;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_DIG_INIT,
        S_DIG,
        S_DIVX_INIT,
        S_DIVX,
        S_DIVY_INIT,
        S_DIVY,
        S_DONE
    } t_hjg_state;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic dig_init;
        logic dig_step;
        logic divx_init;
        logic divy_init;
        logic div_step;
        logic save_x;
        logic out_load;
    } t_hjg_cmd;

    typedef struct packed {
        logic digits_done;
        logic out_free;
    } t_hjg_sts;

endpackage

/* design/hjg_ctrl.sv */
// ----------------------------------------------------------------------------
// hjg_ctrl
// Sequencer for the jitter generator: modulo loop, digit loop, and two
// fraction divisions on the shared restoring divider, then result hand-off.
// ----------------------------------------------------------------------------
module hjg_ctrl #(
    parameter int FRAC_BITS = hjg_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hjg_pkg::t_hjg_sts i_sts,
    output hjg_pkg::t_hjg_cmd o_cmd,
    output logic              o_busy
);

    localparam int MAXSTEP = (hjg_pkg::FRAME_W > FRAC_BITS) ? hjg_pkg::FRAME_W : FRAC_BITS;
    localparam int STEP_W  = $clog2(MAXSTEP);
    localparam logic [STEP_W-1:0] FRAME_LAST = STEP_W'(hjg_pkg::FRAME_W - 1);
    localparam logic [STEP_W-1:0] FRAC_LAST  = STEP_W'(FRAC_BITS - 1);

    hjg_pkg::t_hjg_state r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hjg_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            hjg_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = hjg_pkg::S_MOD;
                end
            end
            hjg_pkg::S_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == FRAME_LAST) begin
                    n_state = hjg_pkg::S_DIG_INIT;
                end
            end
            hjg_pkg::S_DIG_INIT: begin
                o_cmd.dig_init = 1'b1;
                n_state        = hjg_pkg::S_DIG;
            end
            hjg_pkg::S_DIG: begin
                if (i_sts.digits_done) begin
                    n_state = hjg_pkg::S_DIVX_INIT;
                end else begin
                    o_cmd.dig_step = 1'b1;
                end
            end
            hjg_pkg::S_DIVX_INIT: begin
                o_cmd.divx_init = 1'b1;
                n_step          = '0;
                n_state         = hjg_pkg::S_DIVX;
            end
            hjg_pkg::S_DIVX: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == FRAC_LAST) begin
                    n_state = hjg_pkg::S_DIVY_INIT;
                end
            end
            hjg_pkg::S_DIVY_INIT: begin
                o_cmd.save_x    = 1'b1;
                o_cmd.divy_init = 1'b1;
                n_step          = '0;
                n_state         = hjg_pkg::S_DIVY;
            end
            hjg_pkg::S_DIVY: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == FRAC_LAST) begin
                    n_state = hjg_pkg::S_DONE;
                end
            end
            hjg_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = hjg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hjg_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* design/hjg_datapath.sv */
// ----------------------------------------------------------------------------
// hjg_datapath
// Sample count register, shared restoring divider (frame modulo and fraction
// scaling), base-2 and base-3 digit reversal, saturation and output register.
// ----------------------------------------------------------------------------
module hjg_datapath #(
    parameter int MAX_SAMPLES = hjg_pkg::MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = hjg_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic        [hjg_pkg::CFG_W-1:0]   i_wr_data,
    input  logic        [hjg_pkg::FRAME_W-1:0] i_frame_number,
    input  logic                             i_stall,
    input  hjg_pkg::t_hjg_cmd                i_cmd,
    output hjg_pkg::t_hjg_sts                o_sts,
    output logic                             o_valid,
    output logic signed [hjg_pkg::JIT_W-1:0]   o_jitter_x,
    output logic signed [hjg_pkg::JIT_W-1:0]   o_jitter_y
);

    localparam int FW    = hjg_pkg::FRAME_W;
    localparam int JW    = hjg_pkg::JIT_W;
    localparam int CW    = hjg_pkg::CFG_W;
    localparam int NW    = $clog2(MAX_SAMPLES + 1);
    localparam int DW    = NW + 2;
    localparam int RW    = DW + 2;
    localparam int QW    = FRAC_BITS;
    localparam int SH    = NW + 2;
    localparam int PW    = NW + SH;
    localparam int INV3  = (2 ** SH) / 3;

    logic [CW-1:0]        r_seq_len;
    logic [FW-1:0]        r_frame;
    logic [RW-1:0]        r_rem;
    logic [RW-1:0]        r_divisor;
    logic [QW-1:0]        r_quo;
    logic                 r_neg;
    logic [NW-1:0]        r_n2, r_n3;
    logic [DW-1:0]        r_num2, r_den2, r_num3, r_den3;
    logic signed [JW-1:0] r_jx;
    logic signed [JW-1:0] r_out_x, r_out_y;
    logic                 r_out_valid;

    logic [31:0]          c_sc_ext;
    logic [NW-1:0]        c_count;
    logic                 c_in_bit;
    logic [RW-1:0]        c_shift;
    logic                 c_ge;
    logic [RW-1:0]        c_rem_next;
    logic [SH-1:0]        c_inv3;
    logic [PW-1:0]        c_prod;
    logic [NW-1:0]        c_q_est;
    logic [NW+1:0]        c_three_q;
    logic [NW+1:0]        c_r3;
    logic                 c_fix;
    logic [1:0]           c_digit;
    logic [NW-1:0]        c_q3;
    logic [NW-1:0]        c_n_first;
    logic [DW-1:0]        c_sel_num, c_sel_den;
    logic [DW:0]          c_twice, c_den_ext, c_mag;
    logic                 c_neg;
    logic [31:0]          c_quo_ext;
    logic signed [JW-1:0] c_jit;

    assign c_sc_ext = 32'(r_seq_len);

    always_comb begin
        priority if (c_sc_ext == 32'd0) begin
            c_count = NW'(1);
        end else if (c_sc_ext > 32'(MAX_SAMPLES)) begin
            c_count = NW'(MAX_SAMPLES);
        end else begin
            c_count = NW'(r_seq_len);
        end
    end

    assign c_in_bit   = i_cmd.mod_step & r_frame[FW-1];
    assign c_shift    = {r_rem[RW-2:0], c_in_bit};
    assign c_ge       = (c_shift >= r_divisor);
    assign c_rem_next = c_ge ? (c_shift - r_divisor) : c_shift;

    assign c_inv3    = SH'(INV3);
    assign c_prod    = {{SH{1'b0}}, r_n3} * {{NW{1'b0}}, c_inv3};
    assign c_q_est   = c_prod[PW-1:SH];
    assign c_three_q = {2'b00, c_q_est} + {1'b0, c_q_est, 1'b0};
    assign c_r3      = {2'b00, r_n3} - c_three_q;
    assign c_fix     = (c_r3 >= (NW+2)'(3));
    assign c_digit   = c_fix ? 2'(c_r3 - (NW+2)'(3)) : 2'(c_r3);
    assign c_q3      = c_fix ? (c_q_est + NW'(1)) : c_q_est;

    assign c_n_first = r_rem[NW-1:0] + NW'(1);

    assign c_sel_num = i_cmd.divy_init ? r_num3 : r_num2;
    assign c_sel_den = i_cmd.divy_init ? r_den3 : r_den2;
    assign c_twice   = {c_sel_num, 1'b0};
    assign c_den_ext = {1'b0, c_sel_den};
    assign c_neg     = (c_twice < c_den_ext);
    assign c_mag     = c_neg ? (c_den_ext - c_twice) : (c_twice - c_den_ext);

    assign c_quo_ext = 32'(r_quo);

    always_comb begin
        if (r_neg) begin
            if (c_quo_ext > hjg_pkg::JIT_NEG_MAG) begin
                c_jit = JW'(hjg_pkg::JIT_NEG_MAG);
            end else begin
                c_jit = JW'(32'd0 - c_quo_ext);
            end
        end else begin
            if (c_quo_ext > hjg_pkg::JIT_POS_MAX) begin
                c_jit = JW'(hjg_pkg::JIT_POS_MAX);
            end else begin
                c_jit = JW'(c_quo_ext);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len   <= CW'(hjg_pkg::CFG_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_seq_len <= i_wr_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frame   <= i_frame_number;
            r_rem     <= '0;
            r_divisor <= {{(RW-NW){1'b0}}, c_count};
        end
        if (i_cmd.mod_step) begin
            r_frame <= {r_frame[FW-2:0], 1'b0};
        end
        if (i_cmd.mod_step || i_cmd.div_step) begin
            r_rem <= c_rem_next;
            r_quo <= {r_quo[QW-2:0], c_ge};
        end
        if (i_cmd.dig_init) begin
            r_n2   <= c_n_first;
            r_n3   <= c_n_first;
            r_num2 <= '0;
            r_num3 <= '0;
            r_den2 <= DW'(1);
            r_den3 <= DW'(1);
        end
        if (i_cmd.dig_step) begin
            if (r_n2 != '0) begin
                r_num2 <= {r_num2[DW-2:0], r_n2[0]};
                r_den2 <= {r_den2[DW-2:0], 1'b0};
                r_n2   <= {1'b0, r_n2[NW-1:1]};
            end
            if (r_n3 != '0) begin
                r_num3 <= {r_num3[DW-2:0], 1'b0} + r_num3 + DW'(c_digit);
                r_den3 <= {r_den3[DW-2:0], 1'b0} + r_den3;
                r_n3   <= c_q3;
            end
        end
        if (i_cmd.divx_init || i_cmd.divy_init) begin
            r_rem     <= {1'b0, c_mag};
            r_divisor <= {1'b0, c_sel_den, 1'b0};
            r_neg     <= c_neg;
        end
        if (i_cmd.save_x) begin
            r_jx <= c_jit;
        end
        if (i_cmd.out_load) begin
            r_out_x <= r_jx;
            r_out_y <= c_jit;
        end
    end

    assign o_sts.digits_done = (r_n2 == '0) && (r_n3 == '0);
    assign o_sts.out_free    = !r_out_valid || !i_stall;
    assign o_valid           = r_out_valid;
    assign o_jitter_x        = r_out_x;
    assign o_jitter_y        = r_out_y;

endmodule

/* design/halton_jitter_generator.sv */
// ----------------------------------------------------------------------------
// halton_jitter_generator
// Sub-pixel jitter pair from the base-2 and base-3 Halton sequence.
// ----------------------------------------------------------------------------
// A request carries a 32-bit frame number on i_frame_number with i_valid; it
// is taken on a clock edge where i_valid is high and o_stall is low. The frame
// number is reduced modulo the sample count register (i_wr_en/i_wr_data,
// clamped to 1..MAX_SAMPLES), and index+1 is turned into radical inverses in
// base 2 and 3, minus one half, in signed units of 2^-FRAC_BITS pixel.
// The work is done on the shared restoring divider, one bit per cycle (32
// modulo steps and FRAC_BITS steps for each axis), and in the reversal loop,
// one digit per cycle. One request is in flight at a time; o_stall drops at
// the edge that loads the result, so a new request is taken only once the
// previous result is loaded.
// The result is held on o_jitter_x/o_jitter_y with o_valid until taken on an
// edge where i_stall is low; a new request is accepted while it waits, and a
// finished result waits in the controller until the output register frees.
// Reset (i_rst_n low, synchronous) returns to idle, drops o_valid and sets
// the sample count to 8.
// ----------------------------------------------------------------------------
module halton_jitter_generator #(
    parameter int MAX_SAMPLES = hjg_pkg::MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = hjg_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic        [hjg_pkg::CFG_W-1:0]   i_wr_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic        [hjg_pkg::FRAME_W-1:0] i_frame_number,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [hjg_pkg::JIT_W-1:0]   o_jitter_x,
    output logic signed [hjg_pkg::JIT_W-1:0]   o_jitter_y
);

    hjg_pkg::t_hjg_cmd w_cmd;
    hjg_pkg::t_hjg_sts w_sts;

    hjg_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd),
        .o_busy (o_stall)
    );

    hjg_datapath #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (i_wr_en),
        .i_wr_data     (i_wr_data),
        .i_frame_number(i_frame_number),
        .i_stall       (i_stall),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_valid       (o_valid),
        .o_jitter_x    (o_jitter_x),
        .o_jitter_y    (o_jitter_y)
    );

endmodule

/* sim/halton_jitter_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// halton_jitter_checker
// Watches the request, result and sample count ports of the Halton jitter
// generator. For each accepted frame number it works out the exact base-2 and
// base-3 radical inverse of index+1 minus one half, truncated toward zero in
// units of 2^-16 pixel. Each accepted result is compared with the oldest
// outstanding prediction. Mismatch count and outstanding count go to the top.
// ----------------------------------------------------------------------------
module halton_jitter_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [hjg_pkg::CFG_W-1:0]     i_wr_data,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic [hjg_pkg::FRAME_W-1:0]   i_frame_number,
    input  logic                          i_res_valid,
    input  logic                          i_res_stall,
    input  logic signed [hjg_pkg::JIT_W-1:0] i_jitter_x,
    input  logic signed [hjg_pkg::JIT_W-1:0] i_jitter_y,
    output int                            o_errors,
    output int                            o_pending
);

    localparam int FRAC = hjg_pkg::FRAC_BITS_DEF;
    localparam int MAXS = hjg_pkg::MAX_SAMPLES_DEF;
    localparam int JW   = hjg_pkg::JIT_W;
    localparam int CW   = hjg_pkg::CFG_W;
    localparam int FW   = hjg_pkg::FRAME_W;

    typedef struct {
        logic [FW-1:0]       frame;
        logic signed [JW-1:0] x;
        logic signed [JW-1:0] y;
    } t_jitter_pair;

    t_jitter_pair       jitter_due[$];
    logic [CW-1:0]      seq_len;
    int                 mismatch_count;

    function automatic logic signed [JW-1:0] halton_offset(int unsigned n,
                                                           int unsigned base);
        longint unsigned num;
        longint unsigned den;
        longint unsigned twice;
        longint unsigned mag;
        bit              neg;
        num = 0;
        den = 1;
        while (n > 0) begin
            num = num * base + (n % base);
            den = den * base;
            n   = n / base;
        end
        twice = 2 * num;
        neg   = twice < den;
        mag   = neg ? (den - twice) : (twice - den);
        mag   = (mag << FRAC) / (2 * den);
        if (neg) begin
            if (mag > 32768) mag = 32768;
            return JW'(64'd0 - mag);
        end
        if (mag > 32767) mag = 32767;
        return JW'(mag);
    endfunction

    function automatic t_jitter_pair predict_jitter(logic [FW-1:0] frame,
                                                    logic [CW-1:0] cfg);
        t_jitter_pair p;
        int unsigned  count;
        int unsigned  idx;
        count = 32'(cfg);
        if (count == 0) count = 1;
        if (count > MAXS) count = MAXS;
        idx     = frame % count;
        p.frame = frame;
        p.x     = halton_offset(idx + 1, 2);
        p.y     = halton_offset(idx + 1, 3);
        return p;
    endfunction

    always @(posedge i_clk) begin : watch
        t_jitter_pair want;
        if (!i_rst_n) begin
            seq_len        <= CW'(hjg_pkg::CFG_RESET);
            jitter_due.delete();
            mismatch_count = 0;
            o_errors       <= 0;
            o_pending      <= 0;
        end else begin
            if (i_wr_en) seq_len <= i_wr_data;
            if (i_req_valid && !i_req_stall)
                jitter_due.push_back(predict_jitter(i_frame_number, seq_len));
            if (i_res_valid && !i_res_stall) begin
                if (jitter_due.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d", $time,
                             i_jitter_x, i_jitter_y);
                    mismatch_count++;
                end else begin
                    want = jitter_due.pop_front();
                    if (i_jitter_x !== want.x) begin
                        $display("%0t: frame %0d jitter_x expected %0d actual %0d",
                                 $time, want.frame, want.x, i_jitter_x);
                        mismatch_count++;
                    end
                    if (i_jitter_y !== want.y) begin
                        $display("%0t: frame %0d jitter_y expected %0d actual %0d",
                                 $time, want.frame, want.y, i_jitter_y);
                        mismatch_count++;
                    end
                end
            end
            o_errors  <= mismatch_count;
            o_pending <= jitter_due.size();
        end
    end

endmodule

/* sim/tb_halton_jitter_generator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_halton_jitter_generator
// Drives frame number requests and sample count writes into the Halton jitter
// generator with random gaps and result stalls, including one long result
// hold-off that backs the block up. Directed frames cover the field extremes
// and the zero and oversized sample counts; random phases follow under
// several counts. The checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_halton_jitter_generator;

    localparam int ITEMS_PER_PHASE = 106;
    localparam int NUM_PHASES      = 8;
    localparam int HOLD_AT_RESULT  = 80;
    localparam int HOLD_CYCLES     = 300;
    localparam int CW              = hjg_pkg::CFG_W;
    localparam int FW              = hjg_pkg::FRAME_W;
    localparam int JW              = hjg_pkg::JIT_W;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_wr_en;
    logic [CW-1:0]          i_wr_data;
    logic                   i_valid;
    logic                   o_stall;
    logic [FW-1:0]          i_frame_number;
    logic                   o_valid;
    logic                   i_stall;
    logic signed [JW-1:0]   o_jitter_x;
    logic signed [JW-1:0]   o_jitter_y;

    int  errors;
    int  pending;
    bit  no_idle;
    int  results_taken;

    halton_jitter_generator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (i_wr_en),
        .i_wr_data      (i_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_frame_number (i_frame_number),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_jitter_x     (o_jitter_x),
        .o_jitter_y     (o_jitter_y)
    );

    halton_jitter_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (i_wr_en),
        .i_wr_data      (i_wr_data),
        .i_req_valid    (i_valid),
        .i_req_stall    (o_stall),
        .i_frame_number (i_frame_number),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_jitter_x     (o_jitter_x),
        .i_jitter_y     (o_jitter_y),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_frame(logic [FW-1:0] frame);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_frame_number <= frame;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
    endtask

    // drain all outstanding results, then write
    task automatic write_sample_count(logic [CW-1:0] value);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        i_wr_en   <= 1'b1;
        i_wr_data <= value;
        @(posedge i_clk);
        i_wr_en   <= 1'b0;
    endtask

    function automatic logic [FW-1:0] pick_frame();
        unique case ($urandom_range(0, 3))
            0, 1:    return $urandom();
            2:       return $urandom_range(0, 1023);
            default: return 32'hFFFF_FFFF - $urandom_range(0, 511);
        endcase
    endfunction

    initial begin : receiver
        int  hold;
        bit  held_long;
        held_long     = 1'b0;
        results_taken = 0;
        i_stall <= 1'b1;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 4);
            if (!held_long && results_taken >= HOLD_AT_RESULT) begin
                hold      = HOLD_CYCLES;
                held_long = 1'b1;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            results_taken++;
        end
    end

    initial begin : stimulus
        int               fixed_counts[5];
        logic [CW-1:0]    cfg;
        fixed_counts = '{5, 1, 256, 511, 3};
        no_idle        = 1'b0;
        i_rst_n        <= 1'b0;
        i_wr_en        <= 1'b0;
        i_wr_data      <= '0;
        i_valid        <= 1'b0;
        i_frame_number <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset sample count of 8
        send_frame(32'd0);
        send_frame(32'd1);
        send_frame(32'd7);
        send_frame(32'd8);
        send_frame(32'd9);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'h8000_0000);
        send_frame(32'h7FFF_FFFF);
        send_frame(32'hAAAA_AAAA);
        send_frame(32'h5555_5555);

        // zero count acts as one
        write_sample_count(9'd0);
        send_frame(32'd0);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'd12345);

        // oversized count clamps to the maximum
        write_sample_count(9'd511);
        send_frame(32'd255);
        send_frame(32'd256);
        send_frame(32'd511);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'd0);

        write_sample_count(9'd256);
        send_frame(32'd255);
        send_frame(32'h0000_01FF);

        write_sample_count(9'd1);
        send_frame(32'd5);
        send_frame(32'hFFFF_FFFF);

        for (int p = 0; p < NUM_PHASES; p++) begin
            cfg = (p < 5) ? CW'(fixed_counts[p]) : CW'($urandom_range(0, 511));
            write_sample_count(cfg);
            no_idle = (p == 2) || (p == 6);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_frame(pick_frame());
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* halton_jitter_generator.f */
design/hjg_pkg.sv
design/hjg_ctrl.sv
design/hjg_datapath.sv
design/halton_jitter_generator.sv
sim/halton_jitter_checker.sv
sim/tb_halton_jitter_generator.sv
